// ===== hw/rtl/fpa2_pkg.sv =====
// Shared types and constants for the fixed-point atan2 pipeline.
package fpa2_pkg;

    localparam int IN_W     = 32;
    localparam int MAG_W    = 33;
    localparam int Q_W      = 17;
    localparam int R_W      = 18;
    localparam int PROD_W   = 36;
    localparam int ANGLE_W  = 20;
    localparam int DIV_STEPS = 16;
    localparam int FRAC_BITS = 16;

    localparam logic signed [R_W-1:0]     COEF_CUBIC       = 18'sd12864;
    localparam logic signed [R_W-1:0]     COEF_LINEAR      = 18'sd64336;
    localparam logic signed [ANGLE_W-1:0] QUARTER_PI       = 20'sd51471;
    localparam logic signed [ANGLE_W-1:0] THREE_QUARTER_PI = 20'sd154415;

    typedef struct packed {
        logic valid;
        logic y_neg;
        logic x_neg;
        logic r_neg;
    } ctrl_t;

endpackage

// ===== hw/rtl/fpa2_prep.sv =====
// Front stages: magnitude of y plus one, ratio numerator and denominator, numerator magnitude.
module fpa2_prep
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [31:0]            y,
    input  logic signed [31:0]            x,
    output fpa2_pkg::ctrl_t               ctrl,
    output logic [fpa2_pkg::MAG_W-1:0]    mag,
    output logic [fpa2_pkg::MAG_W-1:0]    den
);

    fpa2_pkg::ctrl_t                    s1_ctrl_reg;
    fpa2_pkg::ctrl_t                    s1_ctrl_next;
    logic [fpa2_pkg::MAG_W-1:0]         s1_ay_reg;
    logic [fpa2_pkg::MAG_W-1:0]         s1_ay_next;
    logic signed [31:0]                 s1_x_reg;
    logic [31:0]                        y_abs;

    fpa2_pkg::ctrl_t                    s2_ctrl_reg;
    logic signed [33:0]                 s2_num_reg;
    logic signed [33:0]                 s2_num_next;
    logic [fpa2_pkg::MAG_W-1:0]         s2_den_reg;
    logic [fpa2_pkg::MAG_W-1:0]         s2_den_next;
    logic signed [33:0]                 x_ext;
    logic signed [33:0]                 ay_ext;
    logic signed [33:0]                 den_full;

    fpa2_pkg::ctrl_t                    s3_ctrl_reg;
    fpa2_pkg::ctrl_t                    s3_ctrl_next;
    logic [fpa2_pkg::MAG_W-1:0]         s3_mag_reg;
    logic [fpa2_pkg::MAG_W-1:0]         s3_mag_next;
    logic [fpa2_pkg::MAG_W-1:0]         s3_den_reg;
    logic signed [33:0]                 num_neg;

    always_comb
    begin
        y_abs              = y[31] ? 32'(-y) : 32'(y);
        s1_ay_next         = {1'b0, y_abs} + 33'd1;
        s1_ctrl_next.valid = in_valid;
        s1_ctrl_next.y_neg = y[31];
        s1_ctrl_next.x_neg = x[31];
        s1_ctrl_next.r_neg = 1'b0;
    end

    always_comb
    begin
        x_ext  = {{2{s1_x_reg[31]}}, s1_x_reg};
        ay_ext = $signed({1'b0, s1_ay_reg});
        if (s1_ctrl_reg.x_neg)
        begin
            s2_num_next = x_ext + ay_ext;
            den_full    = ay_ext - x_ext;
        end
        else
        begin
            s2_num_next = x_ext - ay_ext;
            den_full    = x_ext + ay_ext;
        end
        s2_den_next = den_full[fpa2_pkg::MAG_W-1:0];
    end

    always_comb
    begin
        num_neg            = -s2_num_reg;
        s3_mag_next        = s2_num_reg[33] ? num_neg[fpa2_pkg::MAG_W-1:0]
                                            : s2_num_reg[fpa2_pkg::MAG_W-1:0];
        s3_ctrl_next       = s2_ctrl_reg;
        s3_ctrl_next.r_neg = s2_num_reg[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s3_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ay_reg  <= s1_ay_next;
            s1_x_reg   <= x;
            s2_num_reg <= s2_num_next;
            s2_den_reg <= s2_den_next;
            s3_mag_reg <= s3_mag_next;
            s3_den_reg <= s2_den_reg;
        end
    end

    assign ctrl = s3_ctrl_reg;
    assign mag  = s3_mag_reg;
    assign den  = s3_den_reg;

endmodule

// ===== hw/rtl/fpa2_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for the Q16 ratio.
module fpa2_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  fpa2_pkg::ctrl_t               in_ctrl,
    input  logic [fpa2_pkg::MAG_W-1:0]    mag,
    input  logic [fpa2_pkg::MAG_W-1:0]    den,
    output fpa2_pkg::ctrl_t               out_ctrl,
    output logic [fpa2_pkg::Q_W-1:0]      quot
);

    localparam int NS = fpa2_pkg::DIV_STEPS;

    fpa2_pkg::ctrl_t                 ctrl_reg [0:NS];
    logic [fpa2_pkg::Q_W-1:0]        q_reg    [0:NS];
    logic [fpa2_pkg::MAG_W-1:0]      rem_reg  [0:NS-1];
    logic [fpa2_pkg::MAG_W-1:0]      den_reg  [0:NS-1];

    logic                            top_bit;
    logic [fpa2_pkg::MAG_W-1:0]      rem0_next;
    logic [fpa2_pkg::Q_W-1:0]        q0_next;

    // The numerator magnitude never exceeds the divisor, so the top quotient
    // bit is set only when they are equal.
    always_comb
    begin
        top_bit   = (mag >= den);
        rem0_next = top_bit ? (mag - den) : mag;
        q0_next   = {{(fpa2_pkg::Q_W-1){1'b0}}, top_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctrl_reg[0] <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0]   <= q0_next;
            rem_reg[0] <= rem0_next;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        logic [fpa2_pkg::MAG_W:0]    rem_shift;
        logic [fpa2_pkg::MAG_W+1:0]  diff;
        logic                        ge;
        logic [fpa2_pkg::Q_W-1:0]    q_next;

        always_comb
        begin
            rem_shift = {rem_reg[k-1], 1'b0};
            diff      = {1'b0, rem_shift} - {2'b00, den_reg[k-1]};
            ge        = ~diff[fpa2_pkg::MAG_W+1];
            q_next    = {q_reg[k-1][fpa2_pkg::Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= q_next;
            end
        end

        if (k < NS)
        begin : g_rem
            logic [fpa2_pkg::MAG_W-1:0] rem_next;

            always_comb
            begin
                rem_next = ge ? diff[fpa2_pkg::MAG_W-1:0]
                              : rem_shift[fpa2_pkg::MAG_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign out_ctrl = ctrl_reg[NS];
    assign quot     = q_reg[NS];

endmodule

// ===== hw/rtl/fpa2_poly.sv =====
// Cubic correction stages, base angle and sign of the final angle.
module fpa2_poly
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  fpa2_pkg::ctrl_t                     in_ctrl,
    input  logic [fpa2_pkg::Q_W-1:0]            quot,
    output logic                                out_valid,
    output logic signed [fpa2_pkg::ANGLE_W-1:0] angle
);

    fpa2_pkg::ctrl_t                        a_ctrl_reg;
    fpa2_pkg::ctrl_t                        b_ctrl_reg;
    fpa2_pkg::ctrl_t                        c_ctrl_reg;
    fpa2_pkg::ctrl_t                        d_ctrl_reg;
    fpa2_pkg::ctrl_t                        e_ctrl_reg;

    logic signed [fpa2_pkg::R_W-1:0]        r_a_reg;
    logic signed [fpa2_pkg::R_W-1:0]        r_a_next;
    logic signed [fpa2_pkg::R_W-1:0]        r_b_reg;
    logic signed [fpa2_pkg::R_W-1:0]        r_c_reg;
    logic signed [fpa2_pkg::R_W-1:0]        r2_b_reg;
    logic signed [fpa2_pkg::R_W-1:0]        r2_b_next;
    logic signed [fpa2_pkg::R_W-1:0]        u_c_reg;
    logic signed [fpa2_pkg::R_W-1:0]        u_c_next;
    logic signed [fpa2_pkg::R_W-1:0]        p_d_reg;
    logic signed [fpa2_pkg::R_W-1:0]        p_d_next;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    angle_e_reg;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    angle_e_next;

    logic signed [fpa2_pkg::R_W-1:0]        q_pos;
    logic signed [fpa2_pkg::PROD_W-1:0]     prod_b;
    logic signed [fpa2_pkg::PROD_W-1:0]     prod_c;
    logic signed [fpa2_pkg::PROD_W-1:0]     prod_d;
    logic signed [fpa2_pkg::PROD_W-1:0]     shr_b;
    logic signed [fpa2_pkg::PROD_W-1:0]     shr_c;
    logic signed [fpa2_pkg::PROD_W-1:0]     shr_d;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    base;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    sum_e;

    always_comb
    begin
        q_pos    = $signed({1'b0, quot});
        r_a_next = in_ctrl.r_neg ? -q_pos : q_pos;
    end

    always_comb
    begin
        prod_b    = r_a_reg * r_a_reg;
        shr_b     = prod_b >>> fpa2_pkg::FRAC_BITS;
        r2_b_next = shr_b[fpa2_pkg::R_W-1:0];
    end

    always_comb
    begin
        prod_c   = fpa2_pkg::COEF_CUBIC * r2_b_reg;
        shr_c    = prod_c >>> fpa2_pkg::FRAC_BITS;
        u_c_next = $signed(shr_c[fpa2_pkg::R_W-1:0]) - fpa2_pkg::COEF_LINEAR;
    end

    always_comb
    begin
        prod_d   = u_c_reg * r_c_reg;
        shr_d    = prod_d >>> fpa2_pkg::FRAC_BITS;
        p_d_next = shr_d[fpa2_pkg::R_W-1:0];
    end

    always_comb
    begin
        base         = d_ctrl_reg.x_neg ? fpa2_pkg::THREE_QUARTER_PI : fpa2_pkg::QUARTER_PI;
        sum_e        = {{(fpa2_pkg::ANGLE_W-fpa2_pkg::R_W){p_d_reg[fpa2_pkg::R_W-1]}}, p_d_reg}
                       + base;
        angle_e_next = d_ctrl_reg.y_neg ? -sum_e : sum_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
            d_ctrl_reg <= '0;
            e_ctrl_reg <= '0;
        end
        else if (en)
        begin
            a_ctrl_reg <= in_ctrl;
            b_ctrl_reg <= a_ctrl_reg;
            c_ctrl_reg <= b_ctrl_reg;
            d_ctrl_reg <= c_ctrl_reg;
            e_ctrl_reg <= d_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_a_reg     <= r_a_next;
            r_b_reg     <= r_a_reg;
            r2_b_reg    <= r2_b_next;
            r_c_reg     <= r_b_reg;
            u_c_reg     <= u_c_next;
            p_d_reg     <= p_d_next;
            angle_e_reg <= angle_e_next;
        end
    end

    assign out_valid = e_ctrl_reg.valid;
    assign angle     = angle_e_reg;

endmodule

// ===== hw/rtl/fpa2_skid.sv =====
// Output skid register that holds one result while the receiver stalls.
module fpa2_skid
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pipe_valid,
    input  logic signed [fpa2_pkg::ANGLE_W-1:0] pipe_angle,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [fpa2_pkg::ANGLE_W-1:0] out_angle,
    output logic                                full
);

    logic                                   skid_valid_reg;
    logic                                   skid_valid_next;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    skid_angle_reg;
    logic                                   capture;

    always_comb
    begin
        capture         = !skid_valid_reg && pipe_valid && out_stall;
        skid_valid_next = skid_valid_reg ? out_stall : capture;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            skid_angle_reg <= pipe_angle;
        end
    end

    assign out_valid = skid_valid_reg || pipe_valid;
    assign out_angle = skid_valid_reg ? skid_angle_reg : pipe_angle;
    assign full      = skid_valid_reg;

endmodule

// ===== hw/rtl/fixed_point_atan2.sv =====
// Top level of the pipelined fixed-point four-quadrant arctangent.
//
// Input channel xy_valid / xy_stall carries one transaction per (y, x) pair,
// both signed Q16.16. Output channel angle_valid / angle_stall carries one
// transaction per pair: the angle in signed Q4.16 radians, about -pi to pi.
// A transaction moves at a rising edge where valid is high and stall is low.
// Results leave in the order the pairs arrived.
//
// An input transaction passes through three front stages, seventeen divider
// stages (one quotient bit per stage, each a 34-bit compare and subtract),
// and five stages for the cubic term and final sign.
// Throughput is one pair per cycle while the receiver keeps up.
//
// When the receiver stalls, one result moves into a skid register and the
// pipeline keeps going for that cycle; from the next cycle xy_stall is high
// and the whole pipeline holds until the skid register empties.
// Reset clears all valid bits; the block takes pairs from the first cycle
// after reset is released.
module fixed_point_atan2
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               xy_valid,
    output logic               xy_stall,
    input  logic signed [31:0] y,
    input  logic signed [31:0] x,
    output logic               angle_valid,
    input  logic               angle_stall,
    output logic signed [19:0] angle
);

    logic                                   en;
    logic                                   full;
    fpa2_pkg::ctrl_t                        prep_ctrl;
    logic [fpa2_pkg::MAG_W-1:0]             prep_mag;
    logic [fpa2_pkg::MAG_W-1:0]             prep_den;
    fpa2_pkg::ctrl_t                        div_ctrl;
    logic [fpa2_pkg::Q_W-1:0]               div_quot;
    logic                                   pipe_valid;
    logic signed [fpa2_pkg::ANGLE_W-1:0]    pipe_angle;

    assign en       = !full;
    assign xy_stall = full;

    fpa2_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (xy_valid),
        .y        (y),
        .x        (x),
        .ctrl     (prep_ctrl),
        .mag      (prep_mag),
        .den      (prep_den)
    );

    fpa2_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctrl  (prep_ctrl),
        .mag      (prep_mag),
        .den      (prep_den),
        .out_ctrl (div_ctrl),
        .quot     (div_quot)
    );

    fpa2_poly u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctrl   (div_ctrl),
        .quot      (div_quot),
        .out_valid (pipe_valid),
        .angle     (pipe_angle)
    );

    fpa2_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (pipe_valid),
        .pipe_angle (pipe_angle),
        .out_stall  (angle_stall),
        .out_valid  (angle_valid),
        .out_angle  (angle),
        .full       (full)
    );

endmodule

// ===== hw/rtl/fpa2_checker.sv =====
// Port-level assertions for the atan2 block and the bind that attaches them.
module fpa2_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               xy_valid,
    input logic               xy_stall,
    input logic signed [31:0] y,
    input logic signed [31:0] x,
    input logic               angle_valid,
    input logic               angle_stall,
    input logic signed [19:0] angle
);

    // A stalled input transaction stays offered with the same payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        xy_valid && xy_stall |=> xy_valid && $stable(y) && $stable(x))
        else $error("stalled input transaction changed or dropped");

    // A stalled result stays offered with the same value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> angle_valid && $stable(angle))
        else $error("stalled angle transaction changed or dropped");

    // Every angle lies within plus or minus 4.0 radians.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (angle >= -20'sd262144) && (angle <= 20'sd262144))
        else $error("angle out of range");

    // The input is held back only while a result waits at the output.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        xy_stall |-> angle_valid)
        else $error("input stalled with no result pending");

    // Back-pressure on the input starts only after the receiver stalled a result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(xy_stall) |-> $past(angle_valid && angle_stall))
        else $error("input stall without an output stall");

endmodule

bind fixed_point_atan2 fpa2_checker u_fpa2_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .xy_valid    (xy_valid),
    .xy_stall    (xy_stall),
    .y           (y),
    .x           (x),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle)
);

// ===== tb/fixed_point_atan2_test.sv =====
// Self-checking testbench for the fixed-point atan2 pipeline with a bit-exact angle predictor.
module fixed_point_atan2_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_PAIRS = 180;

    typedef struct {
        logic signed [31:0]                y;
        logic signed [31:0]                x;
        logic [fpa2_pkg::ANGLE_W-1:0]      angle;
    } pending_angle_t;

    logic                                clk;
    logic                                rst_n = 1'b0;
    logic                                xy_valid = 1'b0;
    logic                                xy_stall;
    logic signed [31:0]                  y = '0;
    logic signed [31:0]                  x = '0;
    logic                                angle_valid;
    logic                                angle_stall = 1'b0;
    logic signed [fpa2_pkg::ANGLE_W-1:0] angle;

    pending_angle_t pending_angles[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int pairs_sent = 0;
    int angles_checked = 0;
    int cycles = 0;

    fixed_point_atan2 dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .xy_valid    (xy_valid),
        .xy_stall    (xy_stall),
        .y           (y),
        .x           (x),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle       (angle)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [fpa2_pkg::ANGLE_W-1:0] predict_angle(
        input logic signed [31:0] yv,
        input logic signed [31:0] xv);
        longint ys;
        longint xs;
        longint mag;
        longint ratio;
        longint square;
        longint term;
        longint result;
        longint c1;
        longint c3;
        ys = yv;
        xs = xv;
        c1 = fpa2_pkg::COEF_CUBIC;
        c3 = fpa2_pkg::COEF_LINEAR;
        mag = ((ys < 0) ? -ys : ys) + 1;
        if (xs >= 0)
        begin
            ratio = ((xs - mag) * 65536) / (xs + mag);
            result = fpa2_pkg::QUARTER_PI;
        end
        else
        begin
            ratio = ((xs + mag) * 65536) / (mag - xs);
            result = fpa2_pkg::THREE_QUARTER_PI;
        end
        square = (ratio * ratio) >>> 16;
        term = ((((c1 * square) >>> 16) - c3) * ratio) >>> 16;
        result = result + term;
        if (ys < 0)
            result = -result;
        return result[fpa2_pkg::ANGLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    // Scoreboard: predict on input transaction, compare on output transaction.
    always @(posedge clk)
    begin
        pending_angle_t head;
        if (rst_n)
        begin
            if (xy_valid && !xy_stall)
                pending_angles.push_back('{y, x, predict_angle(y, x)});
            if (angle_valid && !angle_stall)
            begin
                if (pending_angles.size() == 0)
                    report_mismatch($sformatf("unexpected angle %0d", angle));
                else
                begin
                    head = pending_angles.pop_front();
                    angles_checked++;
                    if (angle !== head.angle)
                        report_mismatch($sformatf("y=%0d x=%0d angle=%0d want %0d",
                            head.y, head.x, angle, $signed(head.angle)));
                end
            end
        end
    end

    always @(negedge clk)
        angle_stall <= ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("Timed out with %0d angles outstanding.", pending_angles.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_pair(input logic signed [31:0] yv, input logic signed [31:0] xv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            xy_valid <= 1'b0;
            @(negedge clk);
        end
        xy_valid <= 1'b1;
        y <= yv;
        x <= xv;
        do
            @(posedge clk);
        while (xy_stall);
        pairs_sent++;
    endtask

    function automatic logic signed [31:0] random_sign(input logic signed [31:0] v);
        return $urandom_range(1) ? -v : v;
    endfunction

    task automatic test_axes_and_extremes();
        logic signed [31:0] most_neg;
        logic signed [31:0] most_pos;
        most_neg = 32'sh8000_0000;
        most_pos = 32'sh7fff_ffff;
        send_pair(0, 0);
        send_pair(0, 1);
        send_pair(1, 0);
        send_pair(0, -1);
        send_pair(-1, 0);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(65536, 65536);
        send_pair(65536, -65536);
        send_pair(-65536, -65536);
        send_pair(-65536, 65536);
        send_pair(most_neg, 0);
        send_pair(most_neg, most_pos);
        send_pair(most_neg, most_neg);
        send_pair(most_pos, most_pos);
        send_pair(most_pos, most_neg);
        send_pair(0, most_neg);
        send_pair(0, most_pos);
        send_pair(most_pos, 0);
        send_pair(most_pos, 1);
        send_pair(1, most_pos);
        send_pair(-1, most_neg);
        send_pair(32'sh5555_5555, 32'shaaaa_aaaa);
        send_pair(32'shaaaa_aaaa, 32'sh5555_5555);
    endtask

    task automatic test_full_range(input int count);
        repeat (count)
            send_pair($urandom, $urandom);
    endtask

    task automatic test_near_diagonal(input int count);
        logic signed [31:0] mag;
        int delta;
        repeat (count)
        begin
            mag = $urandom >> $urandom_range(1, 31);
            delta = int'($urandom_range(0, 8)) - 4;
            send_pair(random_sign(mag), random_sign(mag) + delta);
        end
    endtask

    task automatic test_small_vectors(input int count);
        repeat (count)
            send_pair(int'($urandom_range(0, 512)) - 256, int'($urandom_range(0, 512)) - 256);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        test_full_range(PHASE_PAIRS / 2);
        test_near_diagonal(PHASE_PAIRS / 3);
        test_small_vectors(PHASE_PAIRS - PHASE_PAIRS / 2 - PHASE_PAIRS / 3);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_axes_and_extremes();
        run_random_phase(10, 71);
        run_random_phase(71, 10);
        run_random_phase(0, 0);
        @(negedge clk);
        xy_valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d coordinate pairs and checked %0d angles,", pairs_sent, angles_checked);
        $display("covering axes, extremes, near-diagonals and three flow-control mixes.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
